FILE: sv/klrt_pkg.sv
// Shared types and constants of the keyed linear ramp table.
package klrt_pkg;

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int FRAC_W = 25;
    localparam int TIME_W = 16;

    // Unity in Q1.24.
    localparam logic [FRAC_W-1:0] FRAC_ONE = 25'h100_0000;

    // Item function codes.
    localparam logic FUNC_SET  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Ramp payload held in one cell.
    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic signed [VAL_W-1:0]  target;
        logic signed [VAL_W-1:0]  start;
        logic [FRAC_W-1:0]        rate;
        logic [FRAC_W-1:0]        frac;
    } ramp_t;

    // What a cell shows to its neighbors.
    typedef struct packed {
        logic  valid;
        ramp_t ramp;
    } slot_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_TICK,
        OP_WRITE,
        OP_REMOVE
    } cell_op_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        cell_op_t op;
        logic     pop;
        logic     push;
        ramp_t    data;
    } cell_cmd_t;

    // Write-back of a ramp that survives a tick.
    typedef struct packed {
        logic  push;
        ramp_t ramp;
    } wb_t;

    // Result leaving the ramp unit.
    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } res_t;

    typedef enum logic {
        ST_IDLE,
        ST_TICK
    } state_t;

endpackage

FILE: sv/klrt_cmd_if.sv
// Input channel of the keyed linear ramp table.
interface klrt_cmd_if
    import klrt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [KEY_W-1:0]        param_key;
    logic signed [VAL_W-1:0] target_value;
    logic signed [VAL_W-1:0] start_value;
    logic [FRAC_W-1:0]       ramp_rate;
    logic                    instant;
    logic [TIME_W-1:0]       time_passed;

    modport source (
        output valid, func, param_key, target_value, start_value, ramp_rate, instant,
               time_passed,
        input  ready
    );

    modport sink (
        input  valid, func, param_key, target_value, start_value, ramp_rate, instant,
               time_passed,
        output ready
    );
endinterface

FILE: sv/klrt_res_if.sv
// Result channel of the keyed linear ramp table.
interface klrt_res_if
    import klrt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [KEY_W-1:0]        out_key;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;

    modport source (
        output valid, out_key, out_value, last,
        input  ready
    );

    modport sink (
        input  valid, out_key, out_value, last,
        output ready
    );
endinterface

FILE: sv/keyed_linear_ramp_table.sv
// Top level of the keyed linear ramp table: cell row, tick sequencer and result register.
//
//   Channel  Dir  Handshake      Payload
//   cmd      in   valid / ready  func, param_key, target_value, start_value,
//                                ramp_rate, instant, time_passed
//   result   out  valid / ready  out_key, out_value, last
//
// A set item, and a tick on an empty table, leave the sequencer idle. A tick over N
// live ramps keeps it busy from its accept: the row pops one ramp a cycle while the
// result side takes items, each ramp passes the pipeline stages (pop, advance,
// saturate, multiply) and reaches the result register through the rounding adder,
// and once the last ramp is through, the sequencer returns to idle.
// Reset clears the live flags of the cells and the control state; ramp payloads are
// left as they are. A stall on the result side freezes the pipeline and the row.
// No new item is taken while a tick is still running.
module keyed_linear_ramp_table
    import klrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input logic              clk,
    input logic              rst_n,
    klrt_cmd_if.sink         cmd,
    klrt_res_if.source       result
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // The head cell sees a filled neighbor below so that a push into an empty row
    // lands there; the top cell sees an empty neighbor above.
    localparam slot_t HEAD_STOP = '{valid: 1'b1, ramp: '0};
    localparam slot_t TOP_STOP  = '{valid: 1'b0, ramp: '0};

    state_t                  state_reg;
    state_t                  state_next;
    logic [CW-1:0]           cnt_reg;
    logic [CW-1:0]           cnt_next;
    logic [CW-1:0]           pop_cnt_reg;
    logic [TIME_W-1:0]       tp_reg;

    logic                    out_valid_reg;
    logic                    out_last_reg;
    logic [KEY_W-1:0]        out_key_reg;
    logic signed [VAL_W-1:0] out_value_reg;

    logic                    en;
    logic                    accept;
    logic                    set_acc;
    logic                    tick_acc;
    logic                    full;
    logic                    hit_any;
    logic                    instant_path;
    logic                    pop_go;
    logic                    unit_busy;
    cell_cmd_t               ctl;
    ramp_t                   set_ramp;
    wb_t                     wb;
    res_t                    res;

    slot_t                   slots  [TABLE_DEPTH];
    logic                    gt_c   [TABLE_DEPTH];
    logic                    kill_c [TABLE_DEPTH];

    // The whole engine advances whenever the result register can take a new item.
    assign en       = !out_valid_reg || result.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && en;
    assign accept   = cmd.valid && cmd.ready;
    assign set_acc  = accept && (cmd.func == FUNC_SET);
    assign tick_acc = accept && (cmd.func == FUNC_TICK);
    assign full     = cnt_reg == CW'(TABLE_DEPTH);
    assign hit_any  = kill_c[TABLE_DEPTH-1];

    // A set for an absent key with no room left is handled as an instant set.
    assign instant_path = cmd.instant || (!hit_any && full);

    assign pop_go = (state_reg == ST_TICK) && (pop_cnt_reg != '0) && en;

    always_comb
    begin
        set_ramp.key    = cmd.param_key;
        set_ramp.target = cmd.target_value;
        set_ramp.start  = cmd.start_value;
        set_ramp.rate   = cmd.ramp_rate;
        set_ramp.frac   = '0;
    end

    always_comb
    begin
        ctl.op   = OP_HOLD;
        ctl.pop  = 1'b0;
        ctl.push = 1'b0;
        ctl.data = set_ramp;
        if (state_reg == ST_TICK)
        begin
            ctl.op   = OP_TICK;
            ctl.pop  = pop_go;
            ctl.push = wb.push;
            ctl.data = wb.ramp;
        end
        else if (set_acc)
        begin
            ctl.op = instant_path ? OP_REMOVE : OP_WRITE;
        end
    end

    // Row of cells, kept sorted by key with the live ramps packed toward the head.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        slot_t below_s;
        slot_t above_s;
        logic  gt_in_s;
        logic  kill_in_s;

        if (i == 0)
        begin : g_head
            assign below_s   = HEAD_STOP;
            assign gt_in_s   = 1'b0;
            assign kill_in_s = 1'b0;
        end
        else
        begin : g_body
            assign below_s   = slots[i-1];
            assign gt_in_s   = gt_c[i-1];
            assign kill_in_s = kill_c[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_top
            assign above_s = TOP_STOP;
        end
        else
        begin : g_mid
            assign above_s = slots[i+1];
        end

        klrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .probe_key (cmd.param_key),
            .hit_any   (hit_any),
            .below     (below_s),
            .above     (above_s),
            .gt_in     (gt_in_s),
            .kill_in   (kill_in_s),
            .cur       (slots[i]),
            .gt_out    (gt_c[i]),
            .kill_out  (kill_c[i])
        );
    end

    klrt_ramp_unit u_unit (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .pop         (pop_go),
        .pop_last    (pop_cnt_reg == CW'(1)),
        .head        (slots[0].ramp),
        .time_passed (tp_reg),
        .wb          (wb),
        .res         (res),
        .busy        (unit_busy)
    );

    // Live ramp count, tracked alongside the row.
    always_comb
    begin
        cnt_next = cnt_reg;
        unique case (ctl.op)
            OP_TICK:   cnt_next = cnt_reg + CW'(ctl.push) - CW'(ctl.pop);
            OP_WRITE:  cnt_next = cnt_reg + CW'(!hit_any);
            OP_REMOVE: cnt_next = cnt_reg - CW'(hit_any);
            OP_HOLD:   cnt_next = cnt_reg;
            default:   cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_acc && (cnt_reg != '0))
                begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK:
            begin
                if ((pop_cnt_reg == '0) && !unit_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pop_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (tick_acc)
            begin
                pop_cnt_reg <= cnt_reg;
            end
            else if (pop_go)
            begin
                pop_cnt_reg <= pop_cnt_reg - CW'(1);
            end
            if (en)
            begin
                out_valid_reg <= res.valid || (set_acc && instant_path);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            tp_reg <= cmd.time_passed;
        end
        if (en)
        begin
            if (res.valid)
            begin
                out_key_reg   <= res.key;
                out_value_reg <= res.value;
                out_last_reg  <= res.last;
            end
            else
            begin
                out_key_reg   <= cmd.param_key;
                out_value_reg <= cmd.target_value;
                out_last_reg  <= 1'b1;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_key   = out_key_reg;
    assign result.out_value = out_value_reg;
    assign result.last      = out_last_reg;

endmodule

FILE: sv/klrt_cell.sv
// One cell of the sorted ramp row: holds a single ramp and trades it with its neighbors.
module klrt_cell
    import klrt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        ctl,
    input  logic [KEY_W-1:0] probe_key,
    input  logic             hit_any,
    input  slot_t            below,
    input  slot_t            above,
    input  logic             gt_in,
    input  logic             kill_in,
    output slot_t            cur,
    output logic             gt_out,
    output logic             kill_out
);

    logic  valid_reg;
    logic  valid_next;
    ramp_t ramp_reg;
    ramp_t ramp_next;
    logic  match;

    assign match    = valid_reg && (ramp_reg.key == probe_key);
    assign gt_out   = !valid_reg || (ramp_reg.key > probe_key);
    assign kill_out = kill_in || match;
    assign cur      = '{valid: valid_reg, ramp: ramp_reg};

    always_comb
    begin
        valid_next = valid_reg;
        ramp_next  = ramp_reg;
        unique case (ctl.op)
            OP_TICK:
            begin
                // The row drains toward the head; survivors join behind the last entry.
                if (ctl.pop)
                begin
                    if (ctl.push && valid_reg && !above.valid)
                    begin
                        valid_next = 1'b1;
                        ramp_next  = ctl.data;
                    end
                    else
                    begin
                        valid_next = above.valid;
                        ramp_next  = above.ramp;
                    end
                end
                else if (ctl.push && !valid_reg && below.valid)
                begin
                    valid_next = 1'b1;
                    ramp_next  = ctl.data;
                end
            end
            OP_WRITE:
            begin
                if (hit_any)
                begin
                    if (match)
                    begin
                        ramp_next = ctl.data;
                    end
                end
                else if (gt_in)
                begin
                    valid_next = below.valid;
                    ramp_next  = below.ramp;
                end
                else if (gt_out)
                begin
                    valid_next = 1'b1;
                    ramp_next  = ctl.data;
                end
            end
            OP_REMOVE:
            begin
                if (kill_out)
                begin
                    valid_next = above.valid;
                    ramp_next  = above.ramp;
                end
            end
            OP_HOLD:
            begin
                valid_next = valid_reg;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ramp_reg <= ramp_next;
    end

endmodule

FILE: sv/klrt_ramp_unit.sv
// Pipelined ramp advance and interpolation for entries popped off the head of the row.
module klrt_ramp_unit
    import klrt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              pop,
    input  logic              pop_last,
    input  ramp_t             head,
    input  logic [TIME_W-1:0] time_passed,
    output wb_t               wb,
    output res_t              res,
    output logic              busy
);

    localparam int INC_W  = FRAC_W + TIME_W;
    localparam int SUM_W  = INC_W + 1;
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;

    // Stage 1: entry as popped.
    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    ramp_t                    s1_ramp_reg;
    // Stage 2: rate times elapsed time.
    logic                     s2_valid_reg;
    logic                     s2_last_reg;
    ramp_t                    s2_ramp_reg;
    logic [INC_W-1:0]         s2_inc_reg;
    // Stage 3: saturated fraction and span.
    logic                     s3_valid_reg;
    logic                     s3_last_reg;
    logic [KEY_W-1:0]         s3_key_reg;
    logic signed [VAL_W-1:0]  s3_start_reg;
    logic signed [DIFF_W-1:0] s3_diff_reg;
    logic [FRAC_W-1:0]        s3_frac_reg;
    // Stage 4: span times fraction.
    logic                     s4_valid_reg;
    logic                     s4_last_reg;
    logic [KEY_W-1:0]         s4_key_reg;
    logic signed [VAL_W-1:0]  s4_start_reg;
    logic signed [PROD_W-1:0] s4_prod_reg;

    logic [SUM_W-1:0]         frac_sum;
    logic                     done;
    logic [FRAC_W-1:0]        frac_new;
    ramp_t                    wb_ramp;

    assign frac_sum = {{(SUM_W-FRAC_W){1'b0}}, s2_ramp_reg.frac} + {1'b0, s2_inc_reg};
    assign done     = frac_sum >= {{(SUM_W-FRAC_W){1'b0}}, FRAC_ONE};
    assign frac_new = done ? FRAC_ONE : frac_sum[FRAC_W-1:0];

    always_comb
    begin
        wb_ramp      = s2_ramp_reg;
        wb_ramp.frac = frac_new;
    end

    assign wb.push = s2_valid_reg && en && !done;
    assign wb.ramp = wb_ramp;

    // Round half up: bit 23 of the signed Q34.24 product carries into the integer step.
    assign res.valid = s4_valid_reg;
    assign res.last  = s4_last_reg;
    assign res.key   = s4_key_reg;
    assign res.value = s4_start_reg + s4_prod_reg[VAL_W+23:24]
                       + {{(VAL_W-1){1'b0}}, s4_prod_reg[23]};

    assign busy = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_last_reg  <= pop_last;
            s1_ramp_reg  <= head;

            s2_last_reg  <= s1_last_reg;
            s2_ramp_reg  <= s1_ramp_reg;
            s2_inc_reg   <= INC_W'(s1_ramp_reg.rate) * INC_W'(time_passed);

            s3_last_reg  <= s2_last_reg;
            s3_key_reg   <= s2_ramp_reg.key;
            s3_start_reg <= s2_ramp_reg.start;
            s3_diff_reg  <= {s2_ramp_reg.target[VAL_W-1], s2_ramp_reg.target}
                            - {s2_ramp_reg.start[VAL_W-1], s2_ramp_reg.start};
            s3_frac_reg  <= frac_new;

            s4_last_reg  <= s3_last_reg;
            s4_key_reg   <= s3_key_reg;
            s4_start_reg <= s3_start_reg;
            s4_prod_reg  <= PROD_W'(s3_diff_reg) * PROD_W'($signed({1'b0, s3_frac_reg}));
        end
    end

endmodule

FILE: test/tb_keyed_linear_ramp_table.sv
// Self-checking testbench of the keyed linear ramp table, with its own ramp predictor.
`timescale 1ns / 100ps

module tb_keyed_linear_ramp_table;
    import klrt_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_ITEMS = 210;
    // The limit lies far above the slowest legal run, in which every tick emits 16 results,
    // each result waits out the longest stall and every item waits out the longest gap.
    localparam int CYCLE_LIMIT  = 600000;
    // A tick over a full table holds the input until its last ramp has left the
    // pipeline; this drain is ample for that.
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // One input item as the driver holds it.
    typedef struct packed {
        logic                    func;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] target;
        logic signed [VAL_W-1:0] start;
        logic [FRAC_W-1:0]       rate;
        logic                    instant;
        logic [TIME_W-1:0]       elapsed;
    } ramp_cmd_t;

    // One parameter write as the block should emit it.
    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } param_write_t;

    logic clk = 1'b0;
    logic rst_n;

    klrt_cmd_if cmd_ch ();
    klrt_res_if res_ch ();

    keyed_linear_ramp_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Items waiting to be driven, and the parameter writes that accepted items owe.
    ramp_cmd_t    pending_cmds[$];
    param_write_t expected_writes[$];

    // The predictor's own copy of the ramp table.
    logic                    live       [TABLE_DEPTH];
    logic [KEY_W-1:0]        live_key   [TABLE_DEPTH];
    logic signed [VAL_W-1:0] live_target[TABLE_DEPTH];
    logic signed [VAL_W-1:0] live_start [TABLE_DEPTH];
    logic [FRAC_W-1:0]       live_rate  [TABLE_DEPTH];
    logic [FRAC_W-1:0]       live_frac  [TABLE_DEPTH];

    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    int error_count    = 0;
    int total_items    = -1;
    int accepted_count = 0;
    int sent_count     = 0;
    int seen_count     = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int cycle_count    = 0;
    ramp_cmd_t held_cmd;

    // Interpolated value start + (target - start) * frac, rounded to nearest with
    // halves going toward plus infinity. The floor of (prod + half) / 2^24 does
    // exactly that, and an arithmetic shift of a signed 64-bit value is that floor.
    function automatic logic signed [VAL_W-1:0] blend(input logic signed [VAL_W-1:0] origin,
                                                      input logic signed [VAL_W-1:0] goal,
                                                      input logic [FRAC_W-1:0] frac);
        longint span;
        longint prod;
        longint sum;
        span = longint'(goal) - longint'(origin);
        prod = span * longint'(frac);
        sum  = longint'(origin) + ((prod + 64'sd8388608) >>> 24);
        return sum[VAL_W-1:0];
    endfunction

    // Applies one accepted item to the predicted table and queues the writes it causes.
    function automatic void update_table(input ramp_cmd_t c);
        int hit;
        int free_slot;
        int best;
        int count;
        logic take_now;
        logic [63:0] acc;
        logic [TABLE_DEPTH-1:0] done;
        param_write_t w;
        if (c.func == FUNC_SET)
        begin
            hit       = -1;
            free_slot = -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (live[i] && live_key[i] == c.key)
                    hit = i;
                else if (!live[i] && free_slot < 0)
                    free_slot = i;
            end
            take_now = c.instant;
            // A new key with no free slot left falls back to an instant set.
            if (!take_now && hit < 0)
            begin
                if (free_slot >= 0)
                    hit = free_slot;
                else
                    take_now = 1'b1;
            end
            if (take_now)
            begin
                if (hit >= 0)
                    live[hit] = 1'b0;
                w.key   = c.key;
                w.value = c.target;
                w.last  = 1'b1;
                expected_writes.push_back(w);
            end
            else
            begin
                live[hit]        = 1'b1;
                live_key[hit]    = c.key;
                live_target[hit] = c.target;
                live_start[hit]  = c.start;
                live_rate[hit]   = c.rate;
                live_frac[hit]   = '0;
            end
        end
        else
        begin
            count = 0;
            done  = '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (live[i])
                    count++;
            // Walk the live ramps in ascending key order.
            for (int n = 0; n < count; n++)
            begin
                best = -1;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (live[i] && !done[i] && (best < 0 || live_key[i] < live_key[best]))
                        best = i;
                done[best] = 1'b1;
                acc = 64'(live_frac[best]) + 64'(live_rate[best]) * 64'(c.elapsed);
                if (acc > FRAC_ONE)
                    acc = FRAC_ONE;
                w.key   = live_key[best];
                w.value = blend(live_start[best], live_target[best], acc[FRAC_W-1:0]);
                w.last  = (n == count - 1);
                expected_writes.push_back(w);
                if (acc == FRAC_ONE)
                    live[best] = 1'b0;
                else
                    live_frac[best] = acc[FRAC_W-1:0];
            end
        end
    endfunction

    // Idle cycles before the next item on either side. Every fourth stretch of
    // items runs back to back so that full-rate behavior is seen as well.
    function automatic int idle_cycles(input int n);
        if ((n % 40) >= 30)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    // Mostly random values, with the range ends and the values around zero now and then.
    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 11))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly slow ramps so that entries live across several ticks.
    function automatic logic [FRAC_W-1:0] rand_rate();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return FRAC_ONE;
            2: return FRAC_W'($urandom_range(0, 32'h100_0000));
            default: return FRAC_W'($urandom_range(1, 32'h4_0000));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] rand_elapsed();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 16'hffff;
            2: return TIME_W'($urandom_range(0, 16'hffff));
            default: return TIME_W'($urandom_range(1, 64));
        endcase
    endfunction

    // Set item. The tick-only field carries random bits that the block must ignore.
    function automatic ramp_cmd_t set_cmd(input logic [KEY_W-1:0] key,
                                          input logic signed [VAL_W-1:0] start,
                                          input logic signed [VAL_W-1:0] target,
                                          input logic [FRAC_W-1:0] rate,
                                          input logic instant);
        ramp_cmd_t c;
        c.func    = FUNC_SET;
        c.key     = key;
        c.start   = start;
        c.target  = target;
        c.rate    = rate;
        c.instant = instant;
        c.elapsed = TIME_W'($urandom);
        return c;
    endfunction

    // Tick item. The set-only fields carry random bits that the block must ignore.
    function automatic ramp_cmd_t tick_cmd(input logic [TIME_W-1:0] elapsed);
        ramp_cmd_t c;
        c.func    = FUNC_TICK;
        c.key     = $urandom;
        c.start   = $urandom;
        c.target  = $urandom;
        c.rate    = FRAC_W'($urandom_range(0, 32'h100_0000));
        c.instant = 1'($urandom);
        c.elapsed = elapsed;
        return c;
    endfunction

    // Driver: presents the pending items in order. The predictor is updated at the
    // very edge where an item is accepted, so expectations always lead the results.
    always @(posedge clk or negedge rst_n)
    begin
        ramp_cmd_t nxt;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            gap_left     <= 0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (cmd_ch.valid)
            begin
                update_table(held_cmd);
                accepted_count <= accepted_count + 1;
            end
            if (gap_left != 0)
            begin
                gap_left     <= gap_left - 1;
                cmd_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                nxt = pending_cmds.pop_front();
                held_cmd            <= nxt;
                cmd_ch.func         <= nxt.func;
                cmd_ch.param_key    <= nxt.key;
                cmd_ch.target_value <= nxt.target;
                cmd_ch.start_value  <= nxt.start;
                cmd_ch.ramp_rate    <= nxt.rate;
                cmd_ch.instant      <= nxt.instant;
                cmd_ch.time_passed  <= nxt.elapsed;
                cmd_ch.valid        <= 1'b1;
                gap_left            <= idle_cycles(sent_count);
                sent_count          <= sent_count + 1;
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks every accepted result against the oldest expected write and
    // then holds ready low for a randomly drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        param_write_t want;
        int stall;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (res_ch.valid && res_ch.ready)
        begin
            if (expected_writes.size() == 0)
            begin
                $display("%0t: result with none expected, actual key %h value %h last %b",
                         $time, res_ch.out_key, res_ch.out_value, res_ch.last);
                error_count++;
            end
            else
            begin
                want = expected_writes.pop_front();
                if (res_ch.out_key !== want.key)
                begin
                    $display("%0t: out_key mismatch, expected %h, actual %h",
                             $time, want.key, res_ch.out_key);
                    error_count++;
                end
                if (res_ch.out_value !== want.value)
                begin
                    $display("%0t: out_value mismatch for key %h, expected %h, actual %h",
                             $time, want.key, want.value, res_ch.out_value);
                    error_count++;
                end
                if (res_ch.last !== want.last)
                begin
                    $display("%0t: last mismatch for key %h, expected %b, actual %b",
                             $time, want.key, want.last, res_ch.last);
                    error_count++;
                end
            end
            stall = idle_cycles(seen_count + 15);
            seen_count <= seen_count + 1;
            if (stall == 0)
                res_ch.ready <= 1'b1;
            else
            begin
                res_ch.ready <= 1'b0;
                stall_left   <= stall - 1;
            end
        end
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d items accepted and %0d writes outstanding",
                     $time, accepted_count, expected_writes.size());
            $display("** keyed_linear_ramp_table: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int made;
        int burst;
        int pick;
        ramp_cmd_t c;

        // Every input is at a known value before the first edge.
        rst_n               = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.func         = FUNC_SET;
        cmd_ch.param_key    = '0;
        cmd_ch.target_value = '0;
        cmd_ch.start_value  = '0;
        cmd_ch.ramp_rate    = '0;
        cmd_ch.instant      = 1'b0;
        cmd_ch.time_passed  = '0;
        res_ch.ready        = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            live[i] = 1'b0;

        // The key pool includes both ends of the key range. It is larger than the
        // table, so well-formed traffic keeps running into the full-table case.
        key_pool[0] = '0;
        key_pool[1] = 32'hffff_ffff;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // Directed part. A tick on an empty table gives nothing, and an instant set
        // on an empty table still writes its target.
        pending_cmds.push_back(tick_cmd(16'd7));
        pending_cmds.push_back(set_cmd(32'h0000_0000, VAL_MAX, VAL_MIN, '0, 1'b1));
        // Full-span ramps in both directions, one of them at a rate of unity.
        pending_cmds.push_back(set_cmd(32'hffff_ffff, VAL_MIN, VAL_MAX, FRAC_ONE, 1'b0));
        pending_cmds.push_back(set_cmd(32'h0000_0000, VAL_MAX, VAL_MIN, 25'd1, 1'b0));
        // A rate of zero never completes.
        pending_cmds.push_back(set_cmd(32'h0000_0005, 32'sh7fff_0000, -32'sd3, '0, 1'b0));
        // Exact halves in both directions check the rounding toward plus infinity.
        pending_cmds.push_back(set_cmd(32'h8000_0000, '0, 32'sd1, 25'h80_0000, 1'b0));
        pending_cmds.push_back(set_cmd(32'h8000_0001, '0, -32'sd1, 25'h80_0000, 1'b0));
        // Zero elapsed time reports every start value; one unit finishes the fast ramp.
        pending_cmds.push_back(tick_cmd('0));
        pending_cmds.push_back(tick_cmd(16'd1));
        // Overwriting a live key restarts its ramp; an instant set removes one.
        pending_cmds.push_back(set_cmd(32'h0000_0000, -32'sd5, 32'sd5, 25'h1000, 1'b0));
        pending_cmds.push_back(set_cmd(32'h8000_0001, VAL_MIN, 32'sh1234_5678, '0, 1'b1));
        pending_cmds.push_back(tick_cmd(16'd3));
        // The longest tick saturates everything except the zero-rate ramp.
        pending_cmds.push_back(tick_cmd(16'hffff));
        pending_cmds.push_back(tick_cmd(16'hffff));
        pending_cmds.push_back(set_cmd(32'h0000_0077, VAL_MIN, VAL_MAX, FRAC_ONE, 1'b1));
        pending_cmds.push_back(set_cmd(32'h0000_0005, '0, VAL_MIN, 25'h1ff_ffff, 1'b1));
        pending_cmds.push_back(tick_cmd(16'd2));

        // Random part, built as rounds of sets on pooled keys, with noise items mixed in, followed by a few ticks.
        // The first round sets more distinct keys than the table holds.
        made = 0;
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
        begin
            pending_cmds.push_back(set_cmd(key_pool[i], rand_value(), rand_value(),
                                           rand_rate(), 1'b0));
            made++;
        end
        while (made < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 10);
            for (int i = 0; i < burst; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    // Noise: every field random, key not drawn from the pool.
                    c.func    = 1'($urandom);
                    c.key     = $urandom;
                    c.target  = $urandom;
                    c.start   = $urandom;
                    c.rate    = FRAC_W'($urandom_range(0, 32'h100_0000));
                    c.instant = 1'($urandom);
                    c.elapsed = TIME_W'($urandom);
                end
                else
                begin
                    c = set_cmd(key_pool[$urandom_range(0, POOL_SIZE - 1)], rand_value(),
                                rand_value(), rand_rate(), ($urandom_range(0, 7) == 0));
                end
                pending_cmds.push_back(c);
                made++;
            end
            burst = $urandom_range(1, 3);
            for (int i = 0; i < burst; i++)
            begin
                pending_cmds.push_back(tick_cmd(rand_elapsed()));
                made++;
            end
        end
        total_items = pending_cmds.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait on the falling edge so that the check does not race the clocked blocks.
        while (!(accepted_count == total_items && expected_writes.size() == 0))
            @(negedge clk);
        // Anything the block still emits now is caught as unexpected.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("** keyed_linear_ramp_table: PASSED **");
        else
            $display("** keyed_linear_ramp_table: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
sv/klrt_pkg.sv
sv/klrt_cmd_if.sv
sv/klrt_res_if.sv
sv/klrt_cell.sv
sv/klrt_ramp_unit.sv
sv/keyed_linear_ramp_table.sv
test/tb_keyed_linear_ramp_table.sv
